[rtl/core/cms_pkg.sv]
`default_nettype none

package cms_pkg;

    // Message type codes.
    localparam logic [2:0] TYPE_STATE    = 3'd0;
    localparam logic [2:0] TYPE_REQUEST  = 3'd1;
    localparam logic [2:0] TYPE_ACK      = 3'd2;
    localparam logic [2:0] TYPE_VARLEN   = 3'd3;
    localparam logic [2:0] TYPE_REVERSE  = 3'd4;

    // Table slots per valid type.
    localparam int unsigned SLOTS_STATE   = 2;
    localparam int unsigned SLOTS_REQUEST = 3;
    localparam int unsigned SLOTS_ACK     = 3;
    localparam int unsigned SLOTS_VARLEN  = 8;
    localparam int unsigned SLOTS_REVERSE = 8;

    // CAN identifiers per type, in the order the frames use them.
    // Unused slots hold zero.
    localparam logic [10:0] ID_TABLE [5][8] = '{
        '{11'h271, 11'h272, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000},
        '{11'h273, 11'h370, 11'h371, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000},
        '{11'h372, 11'h373, 11'h470, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000},
        '{11'h271, 11'h272, 11'h273, 11'h370, 11'h371, 11'h372, 11'h373, 11'h470},
        '{11'h1F0, 11'h1F1, 11'h1F2, 11'h1F3, 11'h2F0, 11'h2F1, 11'h2F2, 11'h2F3}
    };

    // One input word.
    typedef struct packed {
        logic [2:0] msg_type;
        logic [5:0] msg_length;
        logic [7:0] data_byte;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [10:0] can_id;
        logic [63:0] frame_data;
        logic        last_frame;
        logic        rejected;
    } t_result;

    // Identifier lookup; an invalid type gives zero.
    function automatic logic [10:0] lookup_id(input logic [2:0] msg_type,
                                              input logic [2:0] slot);
        logic [10:0] id;
        id = 11'h000;
        if (msg_type <= TYPE_REVERSE) begin
            id = ID_TABLE[msg_type][slot];
        end
        return id;
    endfunction

endpackage

`default_nettype wire

[rtl/core/cms_input_stage.sv]
`default_nettype none

module cms_input_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire cms_pkg::t_item i_item,
    input  wire logic          i_take,
    output logic               o_valid,
    output cms_pkg::t_item     o_item
);

    logic           r_valid;
    logic           n_valid;
    cms_pkg::t_item r_item;
    logic           w_load;

    // The register is free when empty or when its word moves on this cycle.
    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[rtl/core/cms_frame_builder.sv]
`default_nettype none

module cms_frame_builder #(
    parameter int unsigned PAYLOAD_PER_FRAME = 7,
    parameter int unsigned MAX_FRAMES        = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire cms_pkg::t_item  i_item,
    input  wire logic            i_out_free,
    output logic                 o_take,
    output logic                 o_emit,
    output cms_pkg::t_result     o_result
);

    // Longest accepted message per table size, in bytes.
    localparam int unsigned FR_STATE   = (MAX_FRAMES < cms_pkg::SLOTS_STATE) ?
                                         MAX_FRAMES : cms_pkg::SLOTS_STATE;
    localparam int unsigned FR_REQUEST = (MAX_FRAMES < cms_pkg::SLOTS_REQUEST) ?
                                         MAX_FRAMES : cms_pkg::SLOTS_REQUEST;
    localparam int unsigned FR_ACK     = (MAX_FRAMES < cms_pkg::SLOTS_ACK) ?
                                         MAX_FRAMES : cms_pkg::SLOTS_ACK;
    localparam int unsigned FR_VARLEN  = (MAX_FRAMES < cms_pkg::SLOTS_VARLEN) ?
                                         MAX_FRAMES : cms_pkg::SLOTS_VARLEN;
    localparam int unsigned FR_REVERSE = (MAX_FRAMES < cms_pkg::SLOTS_REVERSE) ?
                                         MAX_FRAMES : cms_pkg::SLOTS_REVERSE;
    localparam logic [6:0] CAP_STATE   = 7'(FR_STATE * PAYLOAD_PER_FRAME);
    localparam logic [6:0] CAP_REQUEST = 7'(FR_REQUEST * PAYLOAD_PER_FRAME);
    localparam logic [6:0] CAP_ACK     = 7'(FR_ACK * PAYLOAD_PER_FRAME);
    localparam logic [6:0] CAP_VARLEN  = 7'(FR_VARLEN * PAYLOAD_PER_FRAME);
    localparam logic [6:0] CAP_REVERSE = 7'(FR_REVERSE * PAYLOAD_PER_FRAME);
    localparam logic [2:0] FRAME_FULL  = 3'(PAYLOAD_PER_FRAME);
    localparam int unsigned LANES      = 7;

    logic [55:0] r_frame_bytes,    n_frame_bytes;
    logic [2:0]  r_bytes_in_frame, n_bytes_in_frame;
    logic [5:0]  r_bytes_seen,     n_bytes_seen;
    logic [3:0]  r_frames_left,    n_frames_left;
    logic [2:0]  r_frame_slot,     n_frame_slot;
    logic [3:0]  r_msg_counter,    n_msg_counter;
    logic        r_drop,           n_drop;

    logic        w_start;
    logic [6:0]  w_cap;
    logic        w_bad;
    logic [3:0]  w_frame_count;
    logic        w_drop;
    logic [3:0]  w_frames_left;
    logic [2:0]  w_slot;
    logic [2:0]  w_bif;
    logic [55:0] w_fb;
    logic [55:0] w_fb_new;
    logic [2:0]  w_bif_inc;
    logic [6:0]  w_count;
    logic        w_last;
    logic        w_emit;

    // Length limit of the type's table.
    always_comb begin
        unique case (i_item.msg_type)
            cms_pkg::TYPE_STATE:   w_cap = CAP_STATE;
            cms_pkg::TYPE_REQUEST: w_cap = CAP_REQUEST;
            cms_pkg::TYPE_ACK:     w_cap = CAP_ACK;
            cms_pkg::TYPE_VARLEN:  w_cap = CAP_VARLEN;
            cms_pkg::TYPE_REVERSE: w_cap = CAP_REVERSE;
            default:               w_cap = 7'd0;
        endcase
    end

    // Frames after the first: one per full frame boundary the length passes.
    always_comb begin
        w_frame_count = 4'd0;
        for (int k = 1; k < 8; k++) begin
            if ({1'b0, i_item.msg_length} > 7'(k * PAYLOAD_PER_FRAME)) begin
                w_frame_count = w_frame_count + 4'd1;
            end
        end
    end

    assign w_start = (r_bytes_seen == 6'd0);
    assign w_bad   = (i_item.msg_type > cms_pkg::TYPE_REVERSE) ||
                     (i_item.msg_length == 6'd0) ||
                     ({1'b0, i_item.msg_length} > w_cap);

    // State as seen by this word; a message start clears the frame state.
    assign w_drop        = w_start ? w_bad : r_drop;
    assign w_frames_left = w_start ? (w_bad ? 4'd0 : w_frame_count) : r_frames_left;
    assign w_slot        = w_start ? 3'd0  : r_frame_slot;
    assign w_bif         = w_start ? 3'd0  : r_bytes_in_frame;
    assign w_fb          = w_start ? 56'd0 : r_frame_bytes;

    assign w_count = {1'b0, r_bytes_seen} + 7'd1;
    assign w_last  = (w_count >= {1'b0, i_item.msg_length});

    // Place the byte into its lane.
    always_comb begin
        w_fb_new = w_fb;
        for (int j = 0; j < LANES; j++) begin
            if (w_bif == 3'(j)) begin
                w_fb_new[8*j +: 8] = w_fb[8*j +: 8] | i_item.data_byte;
            end
        end
    end

    assign w_bif_inc = w_bif + 3'd1;
    assign w_emit    = w_drop ? w_last : ((w_bif_inc >= FRAME_FULL) || w_last);

    // A word without a result never waits for the output register.
    assign o_take = i_valid && (i_out_free || !w_emit);
    assign o_emit = w_emit;

    // Result word.
    always_comb begin
        if (w_drop) begin
            o_result.can_id     = 11'd0;
            o_result.frame_data = 64'd0;
            o_result.last_frame = 1'b1;
            o_result.rejected   = 1'b1;
        end else begin
            o_result.can_id     = cms_pkg::lookup_id(i_item.msg_type, w_slot);
            o_result.frame_data = {w_fb_new, r_msg_counter, w_frames_left};
            o_result.last_frame = w_last;
            o_result.rejected   = 1'b0;
        end
    end

    // Next state.
    always_comb begin
        n_frame_bytes    = w_fb;
        n_bytes_in_frame = w_bif;
        n_frames_left    = w_frames_left;
        n_frame_slot     = w_slot;
        n_drop           = w_drop;
        n_msg_counter    = r_msg_counter;
        n_bytes_seen     = w_count[5:0];
        if (!w_drop) begin
            if (w_emit) begin
                n_frame_bytes    = 56'd0;
                n_bytes_in_frame = 3'd0;
                n_frame_slot     = w_slot + 3'd1;
                n_frames_left    = w_frames_left - 4'd1;
            end else begin
                n_frame_bytes    = w_fb_new;
                n_bytes_in_frame = w_bif_inc;
            end
        end
        if (w_last) begin
            if (!w_drop) begin
                n_msg_counter = r_msg_counter + 4'd1;
            end
            n_bytes_seen     = 6'd0;
            n_bytes_in_frame = 3'd0;
            n_frame_bytes    = 56'd0;
            n_frame_slot     = 3'd0;
            n_frames_left    = 4'd0;
            n_drop           = 1'b0;
        end
    end

    // Message and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes    <= 56'd0;
            r_bytes_in_frame <= 3'd0;
            r_bytes_seen     <= 6'd0;
            r_frames_left    <= 4'd0;
            r_frame_slot     <= 3'd0;
            r_msg_counter    <= 4'd0;
            r_drop           <= 1'b0;
        end else if (o_take) begin
            r_frame_bytes    <= n_frame_bytes;
            r_bytes_in_frame <= n_bytes_in_frame;
            r_bytes_seen     <= n_bytes_seen;
            r_frames_left    <= n_frames_left;
            r_frame_slot     <= n_frame_slot;
            r_msg_counter    <= n_msg_counter;
            r_drop           <= n_drop;
        end
    end

endmodule

`default_nettype wire

[rtl/core/cms_output_stage.sv]
`default_nettype none

module cms_output_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire cms_pkg::t_result i_result,
    output logic                  o_free,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output cms_pkg::t_result      o_result
);

    logic             r_valid;
    logic             n_valid;
    cms_pkg::t_result r_result;

    // Free when empty or drained this cycle.
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Result payload, no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[rtl/core/can_message_segmenter_unit.sv]
// CAN message segmenter.
// Input channel (i_in_valid / o_in_ready): one payload byte per word, with the
// message type and total length repeated on every byte of the message.
// Output channel (o_out_valid / i_out_ready): one CAN frame per word, with its
// 11-bit identifier, 64-bit frame data (header in bits 7:0), a last-frame flag
// and a rejected flag. A dropped message gives one rejected word on its last
// byte, with zero identifier and data.
// Path: an accepted byte sits in the input register until the frame builder
// takes it; that take folds it into the frame state and loads the frame it
// completes into the output register, which drives the output channel.
// Throughput: one byte per cycle while the receiver keeps up; the input
// register, the frame state and the output register each advance once a cycle then.
// Bytes that complete no frame pass even while the receiver stalls. A stalled
// frame holds the output register; a following frame-completing byte then
// waits in the input register, and the channel stops after that.
// Reset (synchronous, active low) empties both registers and clears the frame
// state and message counter; o_in_ready is high from the first cycle after.
`default_nettype none

module can_message_segmenter_unit #(
    parameter int unsigned PAYLOAD_PER_FRAME = 7,
    parameter int unsigned MAX_FRAMES        = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_msg_type,
    input  wire logic [5:0]  i_msg_length,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [10:0]      o_can_id,
    output logic [63:0]      o_frame_data,
    output logic             o_last_frame,
    output logic             o_rejected
);

    cms_pkg::t_item   w_in_item;
    cms_pkg::t_item   w_held_item;
    cms_pkg::t_result w_result;
    cms_pkg::t_result w_out_result;
    logic             w_held_valid;
    logic             w_take;
    logic             w_emit;
    logic             w_out_free;

    assign w_in_item.msg_type   = i_msg_type;
    assign w_in_item.msg_length = i_msg_length;
    assign w_in_item.data_byte  = i_data_byte;

    // Input register.
    cms_input_stage u_input (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (w_in_item),
        .i_take  (w_take),
        .o_valid (w_held_valid),
        .o_item  (w_held_item)
    );

    // Frame state and packing.
    cms_frame_builder #(
        .PAYLOAD_PER_FRAME (PAYLOAD_PER_FRAME),
        .MAX_FRAMES        (MAX_FRAMES)
    ) u_builder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_held_valid),
        .i_item     (w_held_item),
        .i_out_free (w_out_free),
        .o_take     (w_take),
        .o_emit     (w_emit),
        .o_result   (w_result)
    );

    // Output register.
    cms_output_stage u_output (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_take && w_emit),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (w_out_result)
    );

    assign o_can_id     = w_out_result.can_id;
    assign o_frame_data = w_out_result.frame_data;
    assign o_last_frame = w_out_result.last_frame;
    assign o_rejected   = w_out_result.rejected;

endmodule

`default_nettype wire

[rtl/core/cms_checker.sv]
`default_nettype none

module cms_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [10:0] o_can_id,
    input wire logic [63:0] o_frame_data,
    input wire logic        o_last_frame,
    input wire logic        o_rejected
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // Reset empties the input register, so the input side opens.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready right after reset");

    // A rejected word is a bare marker closing the message.
    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |->
            (o_last_frame && o_can_id == 11'd0 && o_frame_data == 64'd0))
        else $error("rejected word carries frame contents");

    // A stalled word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_can_id) && $stable(o_frame_data) &&
             $stable(o_last_frame) && $stable(o_rejected)))
        else $error("stalled output word changed");

endmodule

bind can_message_segmenter_unit cms_checker u_cms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_can_id     (o_can_id),
    .o_frame_data (o_frame_data),
    .o_last_frame (o_last_frame),
    .o_rejected   (o_rejected)
);

`default_nettype wire
